FILE: hdl/szb_pkg.sv
// Shared types and constants for the size-class block allocator.
// Used by the controller, the datapath and the top level; no dependencies.
package szb_pkg;

   localparam int OP_W   = 2;
   localparam int ST_W   = 2;
   localparam int SIZE_W = 16;
   localparam int HND_W  = 11;
   localparam int CNT_W  = 11;

   // Register file: four block sizes, then four block counts.
   localparam int SIZE_SLOTS = 4;
   localparam int SLOT_IW    = 2;
   localparam int REG_IW     = 3;
   localparam int ADDR_W     = 5;
   localparam int DATA_W     = 32;
   localparam logic [REG_IW-1:0] CSR_SIZE_BASE  = 3'd0;
   localparam logic [REG_IW-1:0] CSR_COUNT_BASE = 3'd4;

   localparam logic [SIZE_W-1:0] SIZE_RESET [SIZE_SLOTS] =
      '{16'd16, 16'd32, 16'd64, 16'd128};
   localparam logic [CNT_W-1:0]  COUNT_RESET = 11'd256;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_SIZE  = 2'd2,
      OP_INIT  = 2'd3
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK        = 2'd0,
      ST_NONE      = 2'd1,
      ST_RANGE     = 2'd2,
      ST_NOT_ALLOC = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ALLOC_RD,
      S_ALLOC_WR,
      S_HND_CHK,
      S_FREE_WR,
      S_INIT_RUN,
      S_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_item;
      logic alloc_pick;
      logic alloc_pop;
      logic hnd_check;
      logic free_push;
      logic init_step;
      logic out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic alloc_hit;
      logic free_go;
      logic init_last;
      logic rsp_free;
   } stat_type;

endpackage

FILE: hdl/szb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module szb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/szb_ctrl.sv
// Controller state machine for the size-class block allocator.
// Depends on szb_pkg for the state, opcode, command and status types.
module szb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [1:0]        req_operation,
   input  szb_pkg::stat_type stat,
   output logic              req_stall,
   output szb_pkg::cmd_type  cmd
);

   szb_pkg::state_type state_ff, state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         szb_pkg::S_IDLE: begin
            if (req_valid) begin
               unique case (szb_pkg::op_type'(req_operation))
                  szb_pkg::OP_ALLOC: state_in = szb_pkg::S_ALLOC_RD;
                  szb_pkg::OP_INIT:  state_in = szb_pkg::S_INIT_RUN;
                  default:           state_in = szb_pkg::S_HND_CHK;
               endcase
            end
         end
         szb_pkg::S_ALLOC_RD: begin
            state_in = stat.alloc_hit ? szb_pkg::S_ALLOC_WR : szb_pkg::S_FINISH;
         end
         szb_pkg::S_ALLOC_WR: state_in = szb_pkg::S_FINISH;
         szb_pkg::S_HND_CHK: begin
            state_in = stat.free_go ? szb_pkg::S_FREE_WR : szb_pkg::S_FINISH;
         end
         szb_pkg::S_FREE_WR: state_in = szb_pkg::S_FINISH;
         szb_pkg::S_INIT_RUN: begin
            if (stat.init_last) begin
               state_in = szb_pkg::S_FINISH;
            end
         end
         szb_pkg::S_FINISH: begin
            if (stat.rsp_free) begin
               state_in = szb_pkg::S_IDLE;
            end
         end
         default: state_in = szb_pkg::S_IDLE;
      endcase
   end

   // Outputs decoded from the state.
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         szb_pkg::S_IDLE: begin
            req_stall     = 1'b0;
            cmd.load_item = req_valid;
         end
         szb_pkg::S_ALLOC_RD: cmd.alloc_pick = 1'b1;
         szb_pkg::S_ALLOC_WR: cmd.alloc_pop  = 1'b1;
         szb_pkg::S_HND_CHK:  cmd.hnd_check  = 1'b1;
         szb_pkg::S_FREE_WR:  cmd.free_push  = 1'b1;
         szb_pkg::S_INIT_RUN: cmd.init_step  = 1'b1;
         szb_pkg::S_FINISH:   cmd.out_load   = stat.rsp_free;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= szb_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // A finished result waits in FINISH until the output register can take it.
   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == szb_pkg::S_FINISH && !stat.rsp_free) |=> state_ff == szb_pkg::S_FINISH)
      else $error("finish state left while output register busy");

   // The pop stage always follows a successful pool pick.
   a_pop_after_pick: assert property (@(posedge clock) disable iff (reset)
      state_ff == szb_pkg::S_ALLOC_WR |-> $past(state_ff) == szb_pkg::S_ALLOC_RD)
      else $error("pop stage entered without a pick");

   // No new item is taken while one is in flight.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (state_ff != szb_pkg::S_IDLE) |-> req_stall)
      else $error("item taken while busy");

endmodule

FILE: hdl/szb_datapath.sv
// Datapath of the size-class block allocator: registers, pool list state,
// link and flag memories, init sweep and output register.
// Depends on szb_pkg and szb_ram.
module szb_datapath #(
   parameter int NUM_POOLS    = 4,
   parameter int TOTAL_BLOCKS = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  szb_pkg::cmd_type            cmd,
   output szb_pkg::stat_type           stat,
   // Item fields.
   input  logic [szb_pkg::OP_W-1:0]    req_operation,
   input  logic [szb_pkg::SIZE_W-1:0]  req_request_size,
   input  logic [szb_pkg::HND_W-1:0]   req_handle,
   // Result channel.
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [szb_pkg::ST_W-1:0]    rsp_status,
   output logic [szb_pkg::HND_W-1:0]   rsp_block_handle,
   output logic [szb_pkg::SIZE_W-1:0]  rsp_block_size,
   // Register port.
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [szb_pkg::ADDR_W-1:0]  paddr,
   input  logic [szb_pkg::DATA_W-1:0]  pwdata,
   output logic [szb_pkg::DATA_W-1:0]  prdata
);

   localparam int IW        = (TOTAL_BLOCKS > 1) ? $clog2(TOTAL_BLOCKS) : 1;
   localparam int PW        = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
   localparam int SWEEP_LEN = (TOTAL_BLOCKS > NUM_POOLS) ? TOTAL_BLOCKS : NUM_POOLS;
   localparam int SW        = (SWEEP_LEN > 1) ? $clog2(SWEEP_LEN) : 1;
   localparam logic [szb_pkg::CNT_W-1:0] TOTAL_C = szb_pkg::CNT_W'(TOTAL_BLOCKS);

   localparam int CW = szb_pkg::CNT_W;
   localparam int SZ = szb_pkg::SIZE_W;
   localparam int HW = szb_pkg::HND_W;

   // Configuration registers.
   logic [SZ-1:0] size_reg_ff  [szb_pkg::SIZE_SLOTS];
   logic [CW-1:0] count_reg_ff [szb_pkg::SIZE_SLOTS];
   logic [szb_pkg::REG_IW-1:0] reg_idx;
   logic csr_wr;

   assign reg_idx = paddr[szb_pkg::REG_IW+1:2];
   assign csr_wr  = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < szb_pkg::SIZE_SLOTS; i++) begin
            size_reg_ff[i]  <= szb_pkg::SIZE_RESET[i];
            count_reg_ff[i] <= szb_pkg::COUNT_RESET;
         end
      end else if (csr_wr) begin
         if (reg_idx < szb_pkg::CSR_COUNT_BASE) begin
            size_reg_ff[szb_pkg::SLOT_IW'(reg_idx - szb_pkg::CSR_SIZE_BASE)] <= pwdata[SZ-1:0];
         end else begin
            count_reg_ff[szb_pkg::SLOT_IW'(reg_idx - szb_pkg::CSR_COUNT_BASE)] <=
               pwdata[CW-1:0];
         end
      end
   end

   // Register readback.
   always_comb begin
      if (reg_idx < szb_pkg::CSR_COUNT_BASE) begin
         prdata = szb_pkg::DATA_W'(size_reg_ff[szb_pkg::SLOT_IW'(reg_idx)]);
      end else begin
         prdata = szb_pkg::DATA_W'(
            count_reg_ff[szb_pkg::SLOT_IW'(reg_idx - szb_pkg::CSR_COUNT_BASE)]);
      end
   end

   // Item, staged result and sweep registers.
   logic [szb_pkg::OP_W-1:0] op_ff;
   logic [SZ-1:0] reqsize_ff;
   logic [HW-1:0] hnd_ff;
   logic [szb_pkg::ST_W-1:0] res_status_ff, res_status_in;
   logic [HW-1:0] res_handle_ff, res_handle_in;
   logic [SZ-1:0] res_size_ff, res_size_in;
   logic [PW-1:0] sel_ff, sel_in;
   logic [SW-1:0] sweep_ff, sweep_in;
   logic [CW-1:0] used_ff, used_in;

   // Per-pool list state.
   logic [IW-1:0] head_ff [NUM_POOLS];
   logic [IW-1:0] head_in [NUM_POOLS];
   logic [IW-1:0] tail_ff [NUM_POOLS];
   logic [IW-1:0] tail_in [NUM_POOLS];
   logic [CW-1:0] fcnt_ff [NUM_POOLS];
   logic [CW-1:0] fcnt_in [NUM_POOLS];
   logic [CW-1:0] end_ff  [NUM_POOLS];
   logic [CW-1:0] end_in  [NUM_POOLS];

   // Memory ports.
   logic link_we, link_re, flag_we, flag_re;
   logic [IW-1:0] link_waddr, link_raddr, flag_waddr, flag_raddr;
   logic [IW-1:0] link_wdata, link_rdata;
   logic flag_wdata, flag_rdata;

   szb_ram #(.WIDTH(IW), .DEPTH(TOTAL_BLOCKS)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_en   (link_re),
      .rd_addr (link_raddr),
      .rd_data (link_rdata)
   );

   szb_ram #(.WIDTH(1), .DEPTH(TOTAL_BLOCKS)) u_flag_ram (
      .clock   (clock),
      .wr_en   (flag_we),
      .wr_addr (flag_waddr),
      .wr_data (flag_wdata),
      .rd_en   (flag_re),
      .rd_addr (flag_raddr),
      .rd_data (flag_rdata)
   );

   // Allocate: the first pool that is large enough and not empty.
   logic          pick_hit;
   logic [PW-1:0] pick;
   always_comb begin
      pick_hit = 1'b0;
      pick     = '0;
      for (int p = NUM_POOLS - 1; p >= 0; p--) begin
         if (reqsize_ff <= size_reg_ff[p] && fcnt_ff[p] != '0) begin
            pick_hit = 1'b1;
            pick     = PW'(p);
         end
      end
   end

   // Handle checks and the pool that owns the handle.
   logic          hnd_null, hnd_range;
   logic [CW-1:0] hnd_idx;
   logic [PW-1:0] hpool;
   assign hnd_null  = (hnd_ff == '0);
   assign hnd_range = (hnd_ff > end_ff[NUM_POOLS-1]);
   assign hnd_idx   = hnd_ff - 1'b1;
   always_comb begin
      hpool = '0;
      for (int p = NUM_POOLS - 1; p >= 0; p--) begin
         if (hnd_idx < end_ff[p]) begin
            hpool = PW'(p);
         end
      end
   end

   // Init sweep helpers: one pool is laid out in each of the first cycles.
   logic [SW-1:0] sweep_next;
   logic          sweep_mem, sweep_pool;
   logic [PW-1:0] sweep_p;
   logic [CW-1:0] want, room, span_end;
   assign sweep_next = sweep_ff + 1'b1;
   assign sweep_mem  = ({1'b0, sweep_ff} < (SW + 1)'(TOTAL_BLOCKS));
   assign sweep_pool = ({1'b0, sweep_ff} < (SW + 1)'(NUM_POOLS));
   assign sweep_p    = sweep_ff[PW-1:0];
   assign room       = TOTAL_C - used_ff;
   assign want       = (count_reg_ff[szb_pkg::SLOT_IW'(sweep_p)] > room) ?
                       room : count_reg_ff[szb_pkg::SLOT_IW'(sweep_p)];
   assign span_end   = used_ff + want;

   // Next values of datapath state and memory controls.
   always_comb begin
      res_status_in = res_status_ff;
      res_handle_in = res_handle_ff;
      res_size_in   = res_size_ff;
      sel_in        = sel_ff;
      sweep_in      = sweep_ff;
      used_in       = used_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      fcnt_in       = fcnt_ff;
      end_in        = end_ff;
      link_we    = 1'b0;
      link_waddr = '0;
      link_wdata = '0;
      link_re    = 1'b0;
      link_raddr = head_ff[pick];
      flag_we    = 1'b0;
      flag_waddr = '0;
      flag_wdata = 1'b0;
      flag_re    = 1'b0;
      flag_raddr = hnd_idx[IW-1:0];

      if (cmd.load_item) begin
         res_status_in = szb_pkg::ST_OK;
         res_handle_in = '0;
         res_size_in   = '0;
         sweep_in      = '0;
         used_in       = '0;
      end

      // Pick a pool, mark its head block taken and fetch the head's link.
      if (cmd.alloc_pick) begin
         sel_in = pick;
         if (pick_hit) begin
            link_re       = 1'b1;
            flag_we       = 1'b1;
            flag_waddr    = head_ff[pick];
            flag_wdata    = 1'b1;
            res_handle_in = HW'(head_ff[pick]) + 1'b1;
            res_size_in   = size_reg_ff[szb_pkg::SLOT_IW'(pick)];
         end else begin
            res_status_in = szb_pkg::ST_NONE;
         end
      end

      // Dequeue the head block.
      if (cmd.alloc_pop) begin
         fcnt_in[sel_ff] = fcnt_ff[sel_ff] - 1'b1;
         if (fcnt_ff[sel_ff] != CW'(1)) begin
            head_in[sel_ff] = link_rdata;
         end
      end

      // Check the handle; a free also fetches the block's flag.
      if (cmd.hnd_check) begin
         sel_in = hpool;
         if (hnd_null) begin
            res_status_in = szb_pkg::ST_NONE;
         end else if (hnd_range) begin
            res_status_in = szb_pkg::ST_RANGE;
         end else if (op_ff == szb_pkg::OP_SIZE) begin
            res_size_in = size_reg_ff[szb_pkg::SLOT_IW'(hpool)];
         end else begin
            flag_re = 1'b1;
         end
      end

      // Return an allocated block to the tail of its pool's list.
      if (cmd.free_push) begin
         if (flag_rdata) begin
            flag_we    = 1'b1;
            flag_waddr = hnd_idx[IW-1:0];
            flag_wdata = 1'b0;
            if (fcnt_ff[sel_ff] == '0) begin
               head_in[sel_ff] = hnd_idx[IW-1:0];
            end else begin
               link_we    = 1'b1;
               link_waddr = tail_ff[sel_ff];
               link_wdata = hnd_idx[IW-1:0];
            end
            tail_in[sel_ff] = hnd_idx[IW-1:0];
            fcnt_in[sel_ff] = fcnt_ff[sel_ff] + 1'b1;
         end else begin
            res_status_in = szb_pkg::ST_NOT_ALLOC;
         end
      end

      // Init sweep: chain every block to the next, clear its flag and lay out each pool's list.
      if (cmd.init_step) begin
         sweep_in = sweep_next;
         if (sweep_mem) begin
            link_we    = 1'b1;
            link_waddr = sweep_ff[IW-1:0];
            link_wdata = sweep_next[IW-1:0];
            flag_we    = 1'b1;
            flag_waddr = sweep_ff[IW-1:0];
            flag_wdata = 1'b0;
         end
         if (sweep_pool) begin
            head_in[sweep_p] = used_ff[IW-1:0];
            tail_in[sweep_p] = IW'(span_end - 1'b1);
            fcnt_in[sweep_p] = want;
            end_in[sweep_p]  = span_end;
            used_in          = span_end;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff      <= req_operation;
         reqsize_ff <= req_request_size;
         hnd_ff     <= req_handle;
      end
      res_status_ff <= res_status_in;
      res_handle_ff <= res_handle_in;
      res_size_ff   <= res_size_in;
      sel_ff        <= sel_in;
      sweep_ff      <= sweep_in;
      used_ff       <= used_in;
      head_ff       <= head_in;
      tail_ff       <= tail_in;
   end

   // Pools are empty until the first init.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NUM_POOLS; p++) begin
            fcnt_ff[p] <= '0;
            end_ff[p]  <= '0;
         end
      end else begin
         fcnt_ff <= fcnt_in;
         end_ff  <= end_in;
      end
   end

   // Output register.
   logic rsp_valid_ff, rsp_valid_in;
   logic [szb_pkg::ST_W-1:0] rsp_status_ff;
   logic [HW-1:0] rsp_handle_ff;
   logic [SZ-1:0] rsp_size_ff;

   assign rsp_valid_in = cmd.out_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_handle_ff <= res_handle_ff;
         rsp_size_ff   <= res_size_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_block_handle = rsp_handle_ff;
   assign rsp_block_size   = rsp_size_ff;

   assign stat.alloc_hit = pick_hit;
   assign stat.free_go   = (op_ff == szb_pkg::OP_FREE) & ~hnd_null & ~hnd_range;
   assign stat.init_last = (sweep_ff == SW'(SWEEP_LEN - 1));
   assign stat.rsp_free  = ~rsp_valid_ff | ~rsp_stall;

   // A granted handle is never null.
   a_grant_nonnull: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && op_ff == szb_pkg::OP_ALLOC && res_status_ff == szb_pkg::ST_OK)
      |=> rsp_block_handle != '0)
      else $error("allocate granted the null handle");

   // The output register is only overwritten once its beat is gone.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwrote a waiting beat");

endmodule

FILE: hdl/size_class_block_allocator_core.sv
// Top level of the size-class block allocator: four pools of fixed blocks.
// Depends on szb_pkg, szb_ctrl and szb_datapath.
//
//   Channel  Direction  Handshake           Beat
//   req_     in         req_valid/req_stall operation, request_size, handle
//   rsp_     out        rsp_valid/rsp_stall status, block_handle, block_size
//   APB      in/out     psel/penable/pready 8 registers at 4*index
//
// Allocate steps through accept, pick, pop and finish, skipping pop when no pool can
// serve it. Free steps through accept, check, push and finish, skipping push for a
// null or out-of-range handle; get size steps through accept, check and finish.
// Initialize runs a sweep that writes one link and one flag entry per cycle.
// Reset is synchronous; pools stay empty until the first initialize.
// A result stalled at rsp_ holds the block in its finish cycle; one item is
// taken again as soon as the result is in the output register.
module size_class_block_allocator_core #(
   parameter int NUM_POOLS    = 4,
   parameter int TOTAL_BLOCKS = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [szb_pkg::OP_W-1:0]    req_operation,
   input  logic [szb_pkg::SIZE_W-1:0]  req_request_size,
   input  logic [szb_pkg::HND_W-1:0]   req_handle,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [szb_pkg::ST_W-1:0]    rsp_status,
   output logic [szb_pkg::HND_W-1:0]   rsp_block_handle,
   output logic [szb_pkg::SIZE_W-1:0]  rsp_block_size,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [szb_pkg::ADDR_W-1:0]  paddr,
   input  logic [szb_pkg::DATA_W-1:0]  pwdata,
   output logic [szb_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);

   szb_pkg::cmd_type  cmd;
   szb_pkg::stat_type stat;

   assign pready = 1'b1;

   szb_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .stat          (stat),
      .req_stall     (req_stall),
      .cmd           (cmd)
   );

   szb_datapath #(
      .NUM_POOLS    (NUM_POOLS),
      .TOTAL_BLOCKS (TOTAL_BLOCKS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_operation    (req_operation),
      .req_request_size (req_request_size),
      .req_handle       (req_handle),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_block_handle (rsp_block_handle),
      .rsp_block_size   (rsp_block_size),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata)
   );

endmodule

FILE: dv/tb_size_class_block_allocator_core.sv
// Self-checking testbench for the size-class block allocator core.
// Needs szb_pkg and size_class_block_allocator_core; everything else is local.
`timescale 1ns / 1ps

module tb_size_class_block_allocator_core;

   localparam int POOLS  = 4;
   localparam int BLOCKS = 1024;

   typedef struct {
      szb_pkg::status_type             status;
      logic [szb_pkg::HND_W-1:0]       handle;
      logic [szb_pkg::SIZE_W-1:0]      size;
   } grant_type;

   // Pool allocator predictor and the queue of results it still owes.
   class pool_scoreboard;
      logic [szb_pkg::SIZE_W-1:0] size_reg [POOLS];
      logic [szb_pkg::CNT_W-1:0]  count_reg [POOLS];
      logic [9:0]        link [BLOCKS];
      bit                in_use [BLOCKS];
      int                pool_of [BLOCKS];
      logic [9:0]        head [POOLS];
      logic [9:0]        tail [POOLS];
      int                free_cnt [POOLS];
      int                live_total;
      int                granted [$];
      grant_type         owed [$];
      int                errors;

      function new();
         for (int p = 0; p < POOLS; p++) begin
            size_reg[p]  = szb_pkg::SIZE_RESET[p];
            count_reg[p] = szb_pkg::COUNT_RESET;
            head[p] = 0;
            tail[p] = 0;
            free_cnt[p] = 0;
         end
         for (int i = 0; i < BLOCKS; i++) begin
            in_use[i]  = 0;
            pool_of[i] = 0;
         end
         live_total = 0;
         errors = 0;
      endfunction

      function void write_reg(int idx, logic [szb_pkg::DATA_W-1:0] val);
         if (idx < 4) size_reg[idx] = val[szb_pkg::SIZE_W-1:0];
         else count_reg[idx-4] = val[szb_pkg::CNT_W-1:0];
      endfunction

      function void push_block(int p, int idx);
         if (free_cnt[p] == 0) head[p] = idx[9:0];
         else link[tail[p]] = idx[9:0];
         tail[p] = idx[9:0];
         free_cnt[p]++;
      endfunction

      // Work out the result of one accepted beat and update the pool state.
      function void note_request(szb_pkg::op_type op, logic [szb_pkg::SIZE_W-1:0] want,
                                 logic [szb_pkg::HND_W-1:0] hnd);
         grant_type g;
         int        idx;
         int        used;
         int        take;
         g.status = szb_pkg::ST_OK;
         g.handle = '0;
         g.size   = '0;
         case (op)
            szb_pkg::OP_ALLOC: begin
               g.status = szb_pkg::ST_NONE;
               for (int p = 0; p < POOLS; p++) begin
                  if (want <= size_reg[p] && free_cnt[p] != 0) begin
                     idx = head[p];
                     free_cnt[p]--;
                     if (free_cnt[p] != 0) head[p] = link[idx];
                     in_use[idx] = 1;
                     g.status = szb_pkg::ST_OK;
                     g.handle = szb_pkg::HND_W'(idx + 1);
                     g.size   = size_reg[p];
                     granted.push_back(idx + 1);
                     break;
                  end
               end
            end
            szb_pkg::OP_FREE, szb_pkg::OP_SIZE: begin
               if (hnd == 0) g.status = szb_pkg::ST_NONE;
               else if (hnd > live_total) g.status = szb_pkg::ST_RANGE;
               else begin
                  idx = hnd - 1;
                  if (op == szb_pkg::OP_SIZE) g.size = size_reg[pool_of[idx]];
                  else if (!in_use[idx]) g.status = szb_pkg::ST_NOT_ALLOC;
                  else begin
                     in_use[idx] = 0;
                     push_block(pool_of[idx], idx);
                     foreach (granted[i])
                        if (granted[i] == hnd) begin
                           granted.delete(i);
                           break;
                        end
                  end
               end
            end
            default: begin
               // Rebuild every free list; counts are clipped to what is left.
               for (int i = 0; i < BLOCKS; i++) in_use[i] = 0;
               for (int p = 0; p < POOLS; p++) begin
                  head[p] = 0;
                  tail[p] = 0;
                  free_cnt[p] = 0;
               end
               used = 0;
               for (int p = 0; p < POOLS; p++) begin
                  take = count_reg[p];
                  if (take > BLOCKS - used) take = BLOCKS - used;
                  for (int k = 0; k < take; k++) begin
                     pool_of[used+k] = p;
                     push_block(p, used + k);
                  end
                  used += take;
               end
               live_total = used;
               granted.delete();
            end
         endcase
         owed.push_back(g);
      endfunction

      function void check_result(logic [szb_pkg::ST_W-1:0] st,
                                 logic [szb_pkg::HND_W-1:0] hnd,
                                 logic [szb_pkg::SIZE_W-1:0] sz);
         grant_type g;
         if (owed.size() == 0) begin
            $display("%0t: unexpected result beat status=%0d handle=%0d size=%0d",
                     $time, st, hnd, sz);
            errors++;
            return;
         end
         g = owed.pop_front();
         if (st !== g.status) begin
            $display("%0t: status expected %0d actual %0d", $time, g.status, st);
            errors++;
         end
         if (hnd !== g.handle) begin
            $display("%0t: block_handle expected %0d actual %0d", $time, g.handle, hnd);
            errors++;
         end
         if (sz !== g.size) begin
            $display("%0t: block_size expected %0d actual %0d", $time, g.size, sz);
            errors++;
         end
      endfunction
   endclass

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [szb_pkg::OP_W-1:0]      req_operation;
   logic [szb_pkg::SIZE_W-1:0]    req_request_size;
   logic [szb_pkg::HND_W-1:0]     req_handle;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [szb_pkg::ST_W-1:0]      rsp_status;
   logic [szb_pkg::HND_W-1:0]     rsp_block_handle;
   logic [szb_pkg::SIZE_W-1:0]    rsp_block_size;
   logic                          psel;
   logic                          penable;
   logic                          pwrite;
   logic [szb_pkg::ADDR_W-1:0]    paddr;
   logic [szb_pkg::DATA_W-1:0]    pwdata;
   logic [szb_pkg::DATA_W-1:0]    prdata;
   logic                          pready;

   pool_scoreboard sb = new();
   int send_idle_pct;
   int recv_idle_pct;

   size_class_block_allocator_core dut (.*);

   // Free-running clock.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Result side: check accepted beats and stall at random.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_status, rsp_block_handle, rsp_block_size);
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Now and then hold the request channel idle for a random gap.
   task automatic sender_gap();
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   task automatic send_beat(szb_pkg::op_type op, logic [szb_pkg::SIZE_W-1:0] want,
                            logic [szb_pkg::HND_W-1:0] hnd);
      sender_gap();
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_request_size <= want;
      req_handle       <= hnd;
      do @(posedge clock); while (req_stall);
      sb.note_request(op, want, hnd);
   endtask

   // Let every owed result drain so registers can be written safely.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(int idx, logic [szb_pkg::DATA_W-1:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= szb_pkg::ADDR_W'(idx * 4);
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.write_reg(idx, val);
   endtask

   task automatic load_pools(int s0, int s1, int s2, int s3,
                             int c0, int c1, int c2, int c3);
      csr_write(0, s0);
      csr_write(1, s1);
      csr_write(2, s2);
      csr_write(3, s3);
      csr_write(4, c0);
      csr_write(5, c1);
      csr_write(6, c2);
      csr_write(7, c3);
   endtask

   // Mostly well-formed traffic: sized allocations, frees of live blocks, size queries and the odd initialize.
   task automatic random_beat();
      int                          r;
      int                          p;
      logic [szb_pkg::SIZE_W-1:0]  want;
      logic [szb_pkg::HND_W-1:0]   hnd;
      r    = $urandom_range(99);
      p    = $urandom_range(POOLS - 1);
      want = szb_pkg::SIZE_W'($urandom());
      hnd  = szb_pkg::HND_W'($urandom());
      case ($urandom_range(4))
         0: want = sb.size_reg[p];
         1: want = szb_pkg::SIZE_W'(sb.size_reg[p] + 1);
         2: want = szb_pkg::SIZE_W'(sb.size_reg[p] - 1);
         3: want = szb_pkg::SIZE_W'($urandom_range(sb.size_reg[p]));
         default: ;
      endcase
      if (sb.live_total != 0 && $urandom_range(3) != 0)
         hnd = szb_pkg::HND_W'($urandom_range(sb.live_total + 1));
      if (r < 45)
         send_beat(szb_pkg::OP_ALLOC, want, hnd);
      else if (r < 80) begin
         if (sb.granted.size() != 0 && $urandom_range(99) < 85)
            hnd = szb_pkg::HND_W'(sb.granted[$urandom_range(sb.granted.size() - 1)]);
         send_beat(szb_pkg::OP_FREE, want, hnd);
      end else if (r < 97)
         send_beat(szb_pkg::OP_SIZE, want, hnd);
      else
         send_beat(szb_pkg::OP_INIT, want, hnd);
   endtask

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_operation    <= szb_pkg::OP_ALLOC;
      req_request_size <= '0;
      req_handle       <= '0;
      rsp_stall        <= 1'b0;
      psel             <= 1'b0;
      penable          <= 1'b0;
      pwrite           <= 1'b0;
      paddr            <= '0;
      pwdata           <= '0;
      send_idle_pct = 34;
      recv_idle_pct = 75;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Before the first initialize every pool is empty.
      send_beat(szb_pkg::OP_ALLOC, 16'd0, 11'd0);
      send_beat(szb_pkg::OP_FREE, 16'd0, 11'd1);
      send_beat(szb_pkg::OP_SIZE, 16'd0, 11'd0);
      send_beat(szb_pkg::OP_SIZE, 16'd0, 11'd1024);
      send_beat(szb_pkg::OP_INIT, 16'hFFFF, 11'h7FF);
      send_beat(szb_pkg::OP_ALLOC, 16'd0, 11'd0);
      send_beat(szb_pkg::OP_ALLOC, 16'hFFFF, 11'd0);
      send_beat(szb_pkg::OP_ALLOC, 16'd128, 11'd0);
      send_beat(szb_pkg::OP_ALLOC, 16'd17, 11'd0);
      send_beat(szb_pkg::OP_ALLOC, 16'd64, 11'd0);
      // Good free, then a double free, a never-allocated block and bad handles.
      send_beat(szb_pkg::OP_FREE, 16'd0, 11'd1);
      send_beat(szb_pkg::OP_FREE, 16'd0, 11'd1);
      send_beat(szb_pkg::OP_FREE, 16'd0, 11'd2);
      send_beat(szb_pkg::OP_FREE, 16'd0, 11'd0);
      send_beat(szb_pkg::OP_FREE, 16'd0, 11'd1024);
      send_beat(szb_pkg::OP_FREE, 16'd0, 11'd1025);
      send_beat(szb_pkg::OP_SIZE, 16'd0, 11'h7FF);
      send_beat(szb_pkg::OP_SIZE, 16'd0, 11'd300);
      send_beat(szb_pkg::OP_SIZE, 16'd0, 11'd1024);
      wait_drained();

      // Clipping: pool 0 takes every block, later pools get none.
      load_pools(0, 65535, 1, 65534, 1024, 1024, 0, 5);
      send_beat(szb_pkg::OP_INIT, 16'd0, 11'd0);
      send_beat(szb_pkg::OP_ALLOC, 16'd0, 11'd0);
      send_beat(szb_pkg::OP_ALLOC, 16'd1, 11'd0);
      send_beat(szb_pkg::OP_SIZE, 16'd0, 11'd1024);
      wait_drained();

      // Three phases of random traffic, each with its own pool setup.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: load_pools(16, 32, 64, 128, 3, 2, 1, 4);
            1: load_pools(65535, 0, 100, 65535, 0, 1024, 7, 2);
            default: load_pools(8, 8, 200, 1000, 5, 0, 3, 1024);
         endcase
         send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 75 : 0;
         recv_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 34 : 0;
         send_beat(szb_pkg::OP_INIT, 16'd0, 11'd0);
         for (int n = 0; n < 660; n++) random_beat();
         wait_drained();
      end

      if (sb.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #20ms;
      $display("tb: failure");
      $finish;
   end

endmodule
